// ----- sv/dns_name_decompressor_defines.svh -----
// Assertion macros shared by the DNS name decompressor RTL.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef DNS_NAME_DECOMPRESSOR_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define DNSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DNSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dnsd_pkg.sv -----
// Shared types and constants of the DNS name decompressor.
// No dependencies; imported by the top level.
package dnsd_pkg;

  // Default sizes of the message store and the output name buffer
  localparam int MSG_BYTES_DEF = 512;
  localparam int NAME_BUF_DEF  = 256;

  // Fixed field widths
  localparam int LEN_W = 10;
  localparam int CHK_W = LEN_W + 2;

  // Opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  // Label kinds (top two bits of a header byte)
  localparam logic [1:0] KIND_LABEL = 2'b00;
  localparam logic [1:0] KIND_PTR   = 2'b11;

  localparam logic [7:0] LABEL_MASK = 8'h3f;
  localparam logic [7:0] DOT_CHAR   = 8'h2e;
  localparam logic [7:0] ESC_CHAR   = 8'h5c;

  localparam logic [3:0] CHUNK_CHARS = 4'd8;
  localparam logic [2:0] LANE_LAST   = 3'd7;

  typedef struct packed {
    logic       opcode;
    logic [8:0] byte_address;
    logic [7:0] byte_value;
    logic [8:0] start_offset;
    logic [9:0] message_length;
    logic [8:0] out_capacity;
  } dnsd_in_t;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last;
    logic        status;
    logic [9:0]  consumed_length;
  } dnsd_out_t;

endpackage

// ----- sv/dnsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dns_name_decompressor.sv -----
// Top level of the DNS name decompressor: sequencer, counters and message store.
// Depends on dnsd_pkg, dnsd_ram and dns_name_decompressor_defines.svh.
//
// Usage: a word on in_i is taken at a clock edge with start high and busy low.
// A load word (opcode 0) writes one message byte in its accept cycle; busy stays
// low, so loads may follow every cycle. An expand word (opcode 1) raises busy
// until its final result has been driven. The expansion walks the message store
// one byte per read; the store's single registered read port sets this pace.
// Each header or label byte takes a read state and a decode state, an escaped
// dot one more state, a compression pointer a further read and follow state
// for its second byte, and the final result its own state.
// Results appear on res_o for one cycle with res_valid_o high: a full word of
// eight characters whenever eight are collected, then a final word with last,
// status and consumed length. The receiver cannot stall; it must take every
// word in the cycle it is shown.
// Reset returns the sequencer to idle. Store contents stay undefined until
// loaded; no clearing pass runs.
`include "dns_name_decompressor_defines.svh"

module dns_name_decompressor
  import dnsd_pkg::*;
#(
  parameter int MESSAGE_BYTES     = MSG_BYTES_DEF,
  parameter int NAME_BUFFER_BYTES = NAME_BUF_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dnsd_in_t  in_i,
  output logic      res_valid_o,
  output dnsd_out_t res_o
);

  localparam int AW  = $clog2(MESSAGE_BYTES);
  localparam int OCW = $clog2(NAME_BUFFER_BYTES + 1);
  localparam int SW  = OCW + 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_RD,
    ST_HDR,
    ST_CHR_RD,
    ST_CHR,
    ST_ESC,
    ST_PTR_RD,
    ST_PTR,
    ST_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] rp_q, rp_d;
  logic [LEN_W-1:0] start_q, start_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [OCW-1:0]   cap_q, cap_d;
  logic [OCW-1:0]   oc_q, oc_d;
  logic [CHK_W-1:0] chk_q, chk_d;
  logic [LEN_W-1:0] mark_q, mark_d;
  logic [63:0]      acc_q, acc_d;
  logic [2:0]       lane_q, lane_d;
  logic [5:0]       rem_q, rem_d;
  logic [5:0]       ptr_hi_q, ptr_hi_d;
  logic             err_q, err_d;
  logic             res_valid_q, res_valid_d;
  dnsd_out_t        res_q, res_d;

  logic             accept;
  logic             addr_ok;
  logic             ram_we;
  logic [7:0]       rd_data;
  logic [LEN_W-1:0] len_in;
  logic [10:0]      cap_ext;
  logic [OCW-1:0]   cap_in;
  logic [LEN_W-1:0] rp_inc;
  logic [LEN_W-1:0] mark_new;
  logic             oc_nz;
  logic [SW-1:0]    oc_dot;
  logic [SW-1:0]    oc_esc;
  logic [SW-1:0]    cap_w;
  logic [13:0]      target;
  logic [CHK_W-1:0] chk_ptr;
  logic             put_en;
  logic [7:0]       put_chr;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Message store
  assign addr_ok = 32'(in_i.byte_address) < 32'(MESSAGE_BYTES);
  assign ram_we  = accept && (in_i.opcode == OP_LOAD) && addr_ok;

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (MESSAGE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.byte_address)),
    .wdata_i (in_i.byte_value),
    .raddr_i (AW'(rp_q)),
    .rdata_o (rd_data)
  );

  // Clamp length and capacity of a new expansion
  assign len_in  = (32'(in_i.message_length) > 32'(MESSAGE_BYTES)) ?
                   LEN_W'(MESSAGE_BYTES) : in_i.message_length;
  assign cap_ext = (11'(in_i.out_capacity) > 11'(NAME_BUFFER_BYTES)) ?
                   11'(NAME_BUFFER_BYTES) : 11'(in_i.out_capacity);
  assign cap_in  = OCW'(cap_ext);

  // Shared position and count arithmetic
  assign rp_inc   = rp_q + LEN_W'(1);
  assign mark_new = rp_inc - start_q;
  assign oc_nz    = (oc_q != '0);
  assign oc_dot   = SW'(oc_q) + SW'(oc_nz);
  assign oc_esc   = SW'(oc_q) + SW'(rem_q) + SW'(1);
  assign cap_w    = SW'(cap_q);
  assign target   = {ptr_hi_q, rd_data};
  assign chk_ptr  = chk_q + CHK_W'(2);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    start_d     = start_q;
    len_d       = len_q;
    cap_d       = cap_q;
    oc_d        = oc_q;
    chk_d       = chk_q;
    mark_d      = mark_q;
    acc_d       = acc_q;
    lane_d      = lane_q;
    rem_d       = rem_q;
    ptr_hi_d    = ptr_hi_q;
    err_d       = err_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    put_en      = 1'b0;
    put_chr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.opcode == OP_EXPAND)) begin
          len_d   = len_in;
          cap_d   = cap_in;
          start_d = LEN_W'(in_i.start_offset);
          rp_d    = LEN_W'(in_i.start_offset);
          oc_d    = '0;
          chk_d   = '0;
          mark_d  = '0;
          acc_d   = '0;
          lane_d  = '0;
          err_d   = 1'b0;
          if ((cap_in == '0) || (LEN_W'(in_i.start_offset) >= len_in)) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_HDR_RD;
          end
        end
      end

      ST_HDR_RD: begin
        state_d = ST_HDR;
      end

      // Decode a header byte
      ST_HDR: begin
        rp_d = rp_inc;
        if (rd_data == '0) begin
          if (mark_q == '0) begin
            mark_d = mark_new;
          end
          state_d = ST_FIN;
        end else begin
          case (rd_data[7:6])
            KIND_LABEL: begin
              if (oc_nz && (oc_q >= cap_q)) begin
                err_d   = 1'b1;
                state_d = ST_FIN;
              end else begin
                if (oc_nz) begin
                  put_en  = 1'b1;
                  put_chr = DOT_CHAR;
                end
                if ((oc_dot + SW'(rd_data)) >= cap_w) begin
                  err_d   = 1'b1;
                  state_d = ST_FIN;
                end else begin
                  chk_d   = chk_q + CHK_W'(rd_data) + CHK_W'(1);
                  rem_d   = 6'(rd_data & LABEL_MASK);
                  state_d = ST_CHR_RD;
                end
              end
            end
            KIND_PTR: begin
              if (mark_q == '0) begin
                mark_d = mark_new + LEN_W'(1);
              end
              ptr_hi_d = 6'(rd_data & LABEL_MASK);
              if (rp_inc >= len_q) begin
                err_d   = 1'b1;
                state_d = ST_FIN;
              end else begin
                state_d = ST_PTR_RD;
              end
            end
            default: begin
              err_d   = 1'b1;
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_CHR_RD: begin
        if (rp_q >= len_q) begin
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_CHR;
        end
      end

      // Copy one label character, escape a dot first
      ST_CHR: begin
        rp_d = rp_inc;
        if (rd_data == DOT_CHAR) begin
          if (oc_esc >= cap_w) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            put_en  = 1'b1;
            put_chr = ESC_CHAR;
            state_d = ST_ESC;
          end
        end else begin
          put_en  = 1'b1;
          put_chr = rd_data;
          rem_d   = rem_q - 6'd1;
          if (rp_inc >= len_q) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else if (rem_q == 6'd1) begin
            state_d = ST_HDR_RD;
          end else begin
            state_d = ST_CHR_RD;
          end
        end
      end

      // Put the escaped dot itself
      ST_ESC: begin
        put_en  = 1'b1;
        put_chr = DOT_CHAR;
        rem_d   = rem_q - 6'd1;
        if (rp_q >= len_q) begin
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else if (rem_q == 6'd1) begin
          state_d = ST_HDR_RD;
        end else begin
          state_d = ST_CHR_RD;
        end
      end

      ST_PTR_RD: begin
        state_d = ST_PTR;
      end

      // Follow a compression pointer, bound the walk
      ST_PTR: begin
        if (32'(target) >= 32'(len_q)) begin
          err_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          rp_d  = LEN_W'(target);
          chk_d = chk_ptr;
          if (chk_ptr >= CHK_W'(len_q)) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_HDR_RD;
          end
        end
      end

      // Drive the final word
      ST_FIN: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        if (err_q) begin
          res_d.status = 1'b1;
        end else begin
          res_d.name_chars      = acc_q;
          res_d.char_count      = {1'b0, lane_q};
          res_d.consumed_length = mark_q;
        end
        acc_d   = '0;
        lane_d  = '0;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Append a character, flush a full word
    if (put_en) begin
      acc_d[{lane_q, 3'b000} +: 8] = put_chr;
      oc_d = oc_q + OCW'(1);
      if (lane_q == LANE_LAST) begin
        res_valid_d      = 1'b1;
        res_d.name_chars = acc_d;
        res_d.char_count = CHUNK_CHARS;
        acc_d            = '0;
        lane_d           = '0;
      end else begin
        lane_d = lane_q + 3'd1;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      start_q     <= '0;
      len_q       <= '0;
      cap_q       <= '0;
      oc_q        <= '0;
      chk_q       <= '0;
      mark_q      <= '0;
      acc_q       <= '0;
      lane_q      <= '0;
      rem_q       <= '0;
      ptr_hi_q    <= '0;
      err_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      start_q     <= start_d;
      len_q       <= len_d;
      cap_q       <= cap_d;
      oc_q        <= oc_d;
      chk_q       <= chk_d;
      mark_q      <= mark_d;
      acc_q       <= acc_d;
      lane_q      <= lane_d;
      rem_q       <= rem_d;
      ptr_hi_q    <= ptr_hi_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  `DNSD_ASSERT_NOW(a_chunk_full, res_valid_o && !res_o.last,
    (res_o.char_count == CHUNK_CHARS) && !res_o.status, "partial word before the final word")
  `DNSD_ASSERT_NOW(a_err_empty, res_valid_o && res_o.status,
    res_o.last && (res_o.char_count == '0) && (res_o.consumed_length == '0),
    "error word carries data")
  `DNSD_ASSERT_NEXT(a_expand_busy, accept && (in_i.opcode == OP_EXPAND), busy,
    "expansion did not raise busy")
  `DNSD_ASSERT_NEXT(a_last_idle, res_valid_o && res_o.last, !res_valid_o,
    "activity after the final word")

endmodule

// ----- tb/sv/dnsd_checker.sv -----
// Result checker for the DNS name decompressor testbench.
// Mirrors the message store from accepted load words, predicts the result words of
// every accepted expand word and compares them with res_o. Depends on dnsd_pkg.
module dnsd_checker
  import dnsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  dnsd_in_t  in_i,
  input  logic      res_valid_i,
  input  dnsd_out_t res_i,
  output int        mismatch_o,
  output int        pending_o,
  output int        loads_o,
  output int        expands_o,
  output int        words_o,
  output int        error_names_o
);

  localparam int REPORT_MAX = 40;

  // Copy of the message store, filled from the load words seen on the input
  logic [7:0] store_mirror [MSG_BYTES_DEF];

  // Result words still owed by the block, oldest first
  dnsd_out_t   expected_q [$];

  // Text collected for the current expansion but not yet a full word
  logic [63:0] pend_chars;
  int unsigned pend_fill;
  int unsigned out_cnt;

  dnsd_out_t   want;
  int          mismatches;
  int          loads;
  int          expands;
  int          words;
  int          error_names;

  assign mismatch_o    = mismatches;
  assign loads_o       = loads;
  assign expands_o     = expands;
  assign words_o       = words;
  assign error_names_o = error_names;

  initial begin
    mismatches  = 0;
    loads       = 0;
    expands     = 0;
    words       = 0;
    error_names = 0;
    pending_o   = 0;
    pend_chars  = '0;
    pend_fill   = 0;
    out_cnt     = 0;
  end

  // Append one character; queue a full word once eight are collected
  function automatic void push_char(input logic [7:0] ch);
    pend_chars[8*pend_fill +: 8] = ch;
    pend_fill++;
    out_cnt++;
    if (pend_fill == 8) begin
      expected_q.push_back('{name_chars: pend_chars, char_count: CHUNK_CHARS,
                             last: 1'b0, status: 1'b0, consumed_length: '0});
      pend_chars = '0;
      pend_fill  = 0;
    end
  endfunction

  // Walk the labels from origin; return 1 on success with the bytes used at origin
  function automatic bit walk_name(input int unsigned origin, input int unsigned len,
                                   input int unsigned cap, output int unsigned used);
    int unsigned pos, count, checked, target, i;
    logic [7:0]  hdr, ch;
    used    = 0;
    checked = 0;
    if (cap == 0 || origin >= len) return 1'b0;
    pos = origin;
    forever begin
      hdr = store_mirror[pos];
      pos++;
      if (hdr == 8'h00) break;
      count = {24'd0, hdr};
      if (hdr[7:6] == KIND_LABEL) begin
        // separate labels with a dot once any text is out
        if (out_cnt != 0) begin
          if (out_cnt >= cap) return 1'b0;
          push_char(DOT_CHAR);
        end
        if (out_cnt + count >= cap) return 1'b0;
        checked += count + 1;
        for (i = count; i > 0; i--) begin
          if (pos >= len) return 1'b0;
          ch = store_mirror[pos];
          pos++;
          // escape a dot inside a label, leaving room for the rest and the terminator
          if (ch == DOT_CHAR) begin
            if (out_cnt + i + 1 >= cap) return 1'b0;
            push_char(ESC_CHAR);
          end
          push_char(ch);
          if (pos >= len) return 1'b0;
        end
      end else if (hdr[7:6] == KIND_PTR) begin
        // the first pointer fixes how much of the name sits at origin
        if (used == 0) used = pos - origin + 1;
        if (pos >= len) return 1'b0;
        target = {18'd0, hdr[5:0], store_mirror[pos]};
        if (target >= len) return 1'b0;
        pos = target;
        checked += 2;
        if (checked >= len) return 1'b0;
      end else begin
        return 1'b0;
      end
    end
    if (used == 0) used = pos - origin;
    return 1'b1;
  endfunction

  // Queue every result word that one expand word causes
  function automatic void predict_expansion(input dnsd_in_t w);
    int unsigned len, cap, used;
    len = {22'd0, w.message_length};
    if (len > MSG_BYTES_DEF) len = MSG_BYTES_DEF;
    cap = {23'd0, w.out_capacity};
    if (cap > NAME_BUF_DEF) cap = NAME_BUF_DEF;
    pend_chars = '0;
    pend_fill  = 0;
    out_cnt    = 0;
    if (walk_name({23'd0, w.start_offset}, len, cap, used)) begin
      expected_q.push_back('{name_chars: pend_chars, char_count: pend_fill[3:0],
                             last: 1'b1, status: 1'b0, consumed_length: used[9:0]});
    end else begin
      expected_q.push_back('{name_chars: '0, char_count: '0,
                             last: 1'b1, status: 1'b1, consumed_length: '0});
    end
    pend_chars = '0;
    pend_fill  = 0;
  endfunction

  task automatic report_field(input string fname, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, fname, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // compare the word shown this cycle with the oldest expectation
      if (res_valid_i) begin
        words++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result word with none expected, expected none, actual %h",
                     $time, res_i);
        end else begin
          want = expected_q.pop_front();
          if (want.last && want.status) error_names++;
          report_field("name_chars", want.name_chars, res_i.name_chars);
          report_field("char_count", want.char_count, res_i.char_count);
          report_field("last", want.last, res_i.last);
          report_field("status", want.status, res_i.status);
          report_field("consumed_length", want.consumed_length, res_i.consumed_length);
        end
      end
      // track accepted words: mirror loads, predict expansions
      if (start_i && !busy_i) begin
        if (in_i.opcode == OP_LOAD) begin
          store_mirror[in_i.byte_address] = in_i.byte_value;
          loads++;
        end else begin
          predict_expansion(in_i);
          expands++;
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the DNS name decompressor testbench: clock, reset, stimulus and verdict.
// Drives dns_name_decompressor and checks it through dnsd_checker; needs dnsd_pkg.
module testbench;
  import dnsd_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int RANDOM_NAMES  = 32;
  localparam int DRAIN_CYCLES  = 20;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  dnsd_in_t  word_in;
  logic      res_valid;
  dnsd_out_t res_word;

  int mismatches, pending, loads, expands, words, error_names;
  int idle_pct;

  // Message image under construction and the offsets of the names in it
  logic [7:0]  img [MSG_BYTES_DEF];
  int unsigned img_len;
  int unsigned name_starts [$];
  // Store bytes below this address have all been loaded
  int unsigned written_top;

  dns_name_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (word_in),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  dnsd_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .in_i          (word_in),
    .res_valid_i   (res_valid),
    .res_i         (res_word),
    .mismatch_o    (mismatches),
    .pending_o     (pending),
    .loads_o       (loads),
    .expands_o     (expands),
    .words_o       (words),
    .error_names_o (error_names)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random don't-care fields, then the meaningful ones
  function automatic dnsd_in_t random_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(dnsd_in_t)-1:0];
  endfunction

  function automatic dnsd_in_t load_word(input int unsigned addr, input logic [7:0] val);
    dnsd_in_t w;
    w              = random_word();
    w.opcode       = OP_LOAD;
    w.byte_address = addr[8:0];
    w.byte_value   = val;
    return w;
  endfunction

  function automatic dnsd_in_t expand_word(input int unsigned origin, input int unsigned len,
                                           input int unsigned cap);
    dnsd_in_t w;
    w                = random_word();
    w.opcode         = OP_EXPAND;
    w.start_offset   = origin[8:0];
    w.message_length = len[9:0];
    w.out_capacity   = cap[8:0];
    return w;
  endfunction

  // Hold start high until the word is taken, then sometimes drop start and idle
  task automatic send_word(input dnsd_in_t w);
    start   <= 1'b1;
    word_in <= w;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      word_in <= random_word();
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every owed result word has come
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic load_image();
    int unsigned p;
    for (p = 0; p < img_len; p++) send_word(load_word(p, img[p]));
    if (img_len > written_top) written_top = img_len;
  endtask

  function automatic logic [7:0] label_char();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return DOT_CHAR;
    if (pick < 4) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic void place_label(inout int unsigned pos, input string s);
    int k;
    img[pos] = 8'(s.len());
    pos++;
    for (k = 0; k < s.len(); k++) begin
      img[pos] = s[k];
      pos++;
    end
  endfunction

  // Lay out well-formed names; each ends in a zero or points back to an earlier name
  function automatic void build_message(input int unsigned span);
    int unsigned pos, nlab, lab, k, j, tgt;
    name_starts.delete();
    pos = 0;
    while (pos + 4 < span) begin
      name_starts.push_back(pos);
      nlab = $urandom_range(0, 4);
      for (j = 0; j < nlab; j++) begin
        lab = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 10);
        if (pos + lab + 3 >= span) break;
        img[pos] = lab[7:0];
        pos++;
        for (k = 0; k < lab; k++) begin
          img[pos] = label_char();
          pos++;
        end
      end
      if (name_starts.size() > 1 && $urandom_range(0, 1) == 1) begin
        tgt        = name_starts[$urandom_range(0, name_starts.size() - 2)];
        img[pos]   = {2'b11, tgt[13:8]};
        img[pos+1] = tgt[7:0];
        pos += 2;
      end else begin
        img[pos] = 8'h00;
        pos++;
      end
    end
    img_len = pos;
  endfunction

  // Reset, directed cases, then random messages
  initial begin
    int unsigned p, span, origin, len, cap, mode, msg_idx, random_names;
    rst_ni      = 1'b0;
    start       = 1'b0;
    word_in     = '0;
    idle_pct    = 0;
    written_top = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-built message: plain, escaped, pointer, root, reserved and broken names
    p = 0;
    place_label(p, "www");
    place_label(p, "a.bcd");
    place_label(p, "com");
    img[p] = 8'h00; p++;
    place_label(p, "mail");
    img[p] = {2'b11, 6'd0}; img[p+1] = 8'd4; p += 2;
    img[p] = 8'h00; p++;
    img[p] = 8'h40; p++;
    img[p] = 8'h80; p++;
    img[p] = {2'b11, 6'd0}; img[p+1] = 8'hff; p += 2;
    img[p] = {2'b11, 6'd0}; img[p+1] = p[7:0]; p += 2;
    img[p] = 8'd63; p++;
    repeat (63) begin
      img[p] = label_char();
      p++;
    end
    img[p] = 8'h00; p++;
    img_len = p;
    load_image();

    send_word(expand_word(0, 94, 256));
    send_word(expand_word(15, 94, 256));
    send_word(expand_word(22, 94, 256));
    send_word(expand_word(23, 94, 256));
    send_word(expand_word(24, 94, 256));
    send_word(expand_word(25, 94, 256));
    send_word(expand_word(27, 94, 256));
    send_word(expand_word(27, 28, 256));
    send_word(expand_word(29, 94, 256));
    send_word(expand_word(29, 93, 256));
    send_word(expand_word(29, 94, 64));
    send_word(expand_word(29, 94, 63));
    send_word(expand_word(0, 94, 0));
    send_word(expand_word(0, 94, 1));
    send_word(expand_word(0, 94, 15));
    send_word(expand_word(0, 94, 14));
    send_word(expand_word(4, 94, 11));
    send_word(expand_word(4, 94, 10));
    send_word(expand_word(0, 94, 511));
    send_word(expand_word(94, 94, 256));
    send_word(expand_word(0, 0, 256));
    send_word(expand_word(93, 1023, 256));

    // random messages, one idle phase per message, drained in between
    msg_idx      = 0;
    random_names = 0;
    while (random_names < RANDOM_NAMES) begin
      hold_until_drained();
      case (msg_idx % 4)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 0;
        default: idle_pct = 8;
      endcase
      span = $urandom_range(8, 16);
      build_message(span);
      load_image();
      // break the layout now and then with a stray byte
      if ($urandom_range(0, 3) == 0)
        send_word(load_word($urandom_range(0, img_len - 1), 8'($urandom_range(0, 255))));
      repeat ($urandom_range(4, 6)) begin
        mode   = $urandom_range(0, 9);
        origin = name_starts[$urandom_range(0, name_starts.size() - 1)];
        len    = img_len;
        cap    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                             : $urandom_range(32, NAME_BUF_DEF);
        if (mode == 7) begin
          origin = $urandom_range(0, img_len - 1);
          cap    = $urandom_range(0, 511);
        end else if (mode == 8) begin
          // stay inside the loaded part of the store
          origin = $urandom_range(0, written_top);
          len    = $urandom_range(0, written_top);
          cap    = $urandom_range(0, 511);
        end else if (mode == 9) begin
          len = $urandom_range(0, img_len + 2);
          if (len > written_top) len = written_top;
          cap = $urandom_range(NAME_BUF_DEF + 1, 511);
        end
        send_word(expand_word(origin, len, cap));
        random_names++;
      end
      msg_idx++;
    end

    // let the last expansion finish, then a short tail
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d byte loads and %0d expansions (%0d ended in error),",
             loads, expands, error_names);
    $display("checking %0d result words across four idle phases.", words);
    if (mismatches == 0 && pending == 0) begin
      $display("[dns_name_decompressor] OK");
    end else begin
      $display("[dns_name_decompressor] ERROR");
    end
    $finish;
  end

  // Watchdog: a stuck block ends the run here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Cycle limit reached with %0d result words still owed", pending);
    $display("[dns_name_decompressor] ERROR");
    $finish;
  end

endmodule
